>>> hdl/btc_pkg.sv
// ============================================================================
// btc_pkg
// Shared types and constants for the block transposition cipher unit.
// ============================================================================
`default_nettype none

package btc_pkg;

    localparam int unsigned BLOCK_LEN   = 5;      // bytes per block (2..8)
    localparam int unsigned KEY_REGS    = 5;      // key positions with a register
    localparam int unsigned KEY_W       = 3;      // width of one key position
    localparam int unsigned CFG_IDX_W   = 3;      // register index width
    localparam int unsigned CFG_DATA_W  = 3;      // register data width
    localparam int unsigned QUEUE_DEPTH = 2;      // blocks between front and back

    localparam logic [7:0] PAD_BYTE = 8'h7A;      // 'z'

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_POS0     = 3'd1;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

>>> hdl/btc_if.sv
// ============================================================================
// btc_if
// Handshake channels of the cipher unit: message word in, cipher word out,
// register writes.
// ============================================================================
`default_nettype none

interface btc_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface btc_cipher_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       block_end;
    logic       message_end;

    modport source (output valid, out_byte, block_end, message_end, input ready);
    modport sink   (input valid, out_byte, block_end, message_end, output ready);
endinterface

interface btc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [btc_pkg::CFG_IDX_W-1:0]    index;
    logic [btc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/btc_front.sv
// ============================================================================
// btc_front
// Collects message words into a block, pads a short final block with 'z'
// and pushes the finished block into the queue.
// ============================================================================
`default_nettype none

module btc_front #(
    parameter int unsigned BLOCK_LEN = btc_pkg::BLOCK_LEN
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    btc_msg_if.sink                        msg,
    input  wire btc_pkg::q_status_t        q_status,
    output logic                           push,
    output logic [BLOCK_LEN*8:0]           push_data
);

    localparam int unsigned FILL_W = $clog2(BLOCK_LEN);

    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [BLOCK_LEN-1:0][7:0]  block_reg, block_next;
    logic                       ready_int;
    logic                       accept;
    logic                       complete;

    assign ready_int = !q_status.full;
    assign msg.ready = ready_int;
    assign accept    = msg.valid && ready_int;
    assign complete  = (fill_reg == FILL_W'(BLOCK_LEN - 1)) || msg.final_byte;

    // new word at the fill slot; on a final word every later slot is padded
    always_comb
    begin
        for (int i = 0; i < BLOCK_LEN; i++)
        begin
            if (FILL_W'(i) == fill_reg)
                block_next[i] = msg.data_byte;
            else if (msg.final_byte && (FILL_W'(i) > fill_reg))
                block_next[i] = btc_pkg::PAD_BYTE;
            else
                block_next[i] = block_reg[i];
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (accept)
            fill_next = complete ? '0 : fill_reg + 1'b1;
    end

    assign push      = accept && complete;
    assign push_data = {msg.final_byte, block_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            block_reg <= block_next;
    end

endmodule

`default_nettype wire

>>> hdl/btc_queue.sv
// ============================================================================
// btc_queue
// Short block queue between the front and back parts.
// ============================================================================
`default_nettype none

module btc_queue #(
    parameter int unsigned WIDTH = btc_pkg::BLOCK_LEN * 8 + 1,
    parameter int unsigned DEPTH = btc_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        head_data,
    output btc_pkg::q_status_t      status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("block pushed into full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

`default_nettype wire

>>> hdl/btc_back.sv
// ============================================================================
// btc_back
// Drains the head block one permuted word per cycle, while the receiver is ready, into the output register.
// ============================================================================
`default_nettype none

module btc_back #(
    parameter int unsigned BLOCK_LEN = btc_pkg::BLOCK_LEN
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        decrypt_mode,
    input  wire logic [BLOCK_LEN-1:0][btc_pkg::KEY_W-1:0]    key_vec,
    input  wire logic [BLOCK_LEN*8:0]                        head_data,
    input  wire btc_pkg::q_status_t                          q_status,
    output logic                                             pop,
    btc_cipher_if.source                                     cipher
);

    localparam int unsigned IDX_W = $clog2(BLOCK_LEN);
    localparam int unsigned KW    = btc_pkg::KEY_W;
    localparam logic [KW:0] LEN_X = (KW + 1)'(BLOCK_LEN);

    logic [BLOCK_LEN-1:0][7:0]    head_bytes;
    logic                         head_final;
    logic [BLOCK_LEN-1:0][KW-1:0] src;
    logic [BLOCK_LEN-1:0]         src_oob;
    logic [KW-1:0]                sel_key;
    logic                         sel_oob;
    logic [7:0]                   sel_byte;
    logic                         last;
    logic                         load;

    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic             block_end_reg;
    logic             message_end_reg;

    assign head_final = head_data[BLOCK_LEN*8];
    assign head_bytes = head_data[BLOCK_LEN*8-1:0];

    // source position per output slot; inverse keeps the last match, else 0
    always_comb
    begin
        for (int j = 0; j < BLOCK_LEN; j++)
        begin
            if (decrypt_mode)
            begin
                src[j]     = '0;
                src_oob[j] = 1'b0;
                for (int i = 0; i < BLOCK_LEN; i++)
                begin
                    if (key_vec[i] == KW'(j))
                        src[j] = KW'(i);
                end
            end
            else
            begin
                src[j]     = key_vec[j];
                src_oob[j] = ({1'b0, key_vec[j]} >= LEN_X);
            end
        end
    end

    assign sel_key  = src[pos_reg];
    assign sel_oob  = src_oob[pos_reg];
    assign sel_byte = sel_oob ? btc_pkg::PAD_BYTE : head_bytes[sel_key[IDX_W-1:0]];

    assign last = (pos_reg == IDX_W'(BLOCK_LEN - 1));
    assign load = (!out_valid_reg || cipher.ready) && !q_status.empty;
    assign pop  = load && last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || cipher.ready)
            out_valid_next = !q_status.empty;
        if (load)
            pos_next = last ? '0 : pos_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= sel_byte;
            block_end_reg   <= last;
            message_end_reg <= last && head_final;
        end
    end

    assign cipher.valid       = out_valid_reg;
    assign cipher.out_byte    = out_byte_reg;
    assign cipher.block_end   = block_end_reg;
    assign cipher.message_end = message_end_reg;

    a_pop_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_mid_block_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != '0) |-> !q_status.empty)
        else $error("block left queue before it was drained");

    a_msg_end_on_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && message_end_reg) |-> block_end_reg)
        else $error("message end away from block end");

endmodule

`default_nettype wire

>>> hdl/block_transposition_cipher_unit.sv
// ============================================================================
// block_transposition_cipher_unit
// Block transposition cipher: words are grouped into blocks, a short final
// block is padded with 'z', and each block leaves permuted by the key.
// ============================================================================
// Throughput: one message word accepted per cycle while the queue has room;
//   BLOCK_LEN cipher words per block, one per cycle while the receiver is ready.
// Path: the word that completes a block pushes it into the queue; once at the
//   head, its first word loads into the single output register when that is free.
// Reset: fill count, queue and output valid clear; encrypt mode, identity key.
// ============================================================================
`default_nettype none

module block_transposition_cipher_unit #(
    parameter int unsigned BLOCK_LEN = btc_pkg::BLOCK_LEN
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    btc_msg_if.sink        msg,
    btc_cipher_if.source   cipher,
    btc_cfg_if.sink        cfg
);

    localparam int unsigned KW   = btc_pkg::KEY_W;
    localparam int unsigned QW   = BLOCK_LEN * 8 + 1;   // block bytes plus final flag
    localparam int unsigned NREG = btc_pkg::KEY_REGS;

    // configuration registers
    logic                         decrypt_mode_reg;
    logic [KW-1:0]                key_pos_reg [NREG];
    logic [BLOCK_LEN-1:0][KW-1:0] key_vec;
    logic                         cfg_write;

    // front/back link
    logic                         push;
    logic [QW-1:0]                push_data;
    logic                         pop;
    logic [QW-1:0]                head_data;
    btc_pkg::q_status_t           q_status;

    // register writes are always taken; unknown indexes drop out
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_mode_reg <= 1'b0;
            for (int k = 0; k < NREG; k++)
                key_pos_reg[k] <= KW'(k);
        end
        else if (cfg_write)
        begin
            if (cfg.index == btc_pkg::REG_DECRYPT_MODE)
                decrypt_mode_reg <= cfg.data[0];
            for (int k = 0; k < NREG; k++)
            begin
                if (cfg.index == btc_pkg::REG_KEY_POS0 + btc_pkg::CFG_IDX_W'(k))
                    key_pos_reg[k] <= cfg.data;
            end
        end
    end

    // positions past the key registers stay at identity
    for (genvar g = 0; g < BLOCK_LEN; g++)
    begin : g_key
        if (g < NREG)
        begin : g_reg
            assign key_vec[g] = key_pos_reg[g];
        end
        else
        begin : g_ident
            assign key_vec[g] = KW'(g);
        end
    end

    // front: gathers words and pads, pushes whole blocks
    btc_front #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // two blocks of slack so a block fills while the previous one drains
    btc_queue #(
        .WIDTH (QW),
        .DEPTH (btc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    // back: permutes the head block out, one word per cycle while the receiver is ready
    btc_back #(
        .BLOCK_LEN (BLOCK_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .decrypt_mode (decrypt_mode_reg),
        .key_vec      (key_vec),
        .head_data    (head_data),
        .q_status     (q_status),
        .pop          (pop),
        .cipher       (cipher)
    );

endmodule

`default_nettype wire

>>> dv/tb_block_transposition_cipher_unit.sv
// ----------------------------------------------------------------------------
// tb_block_transposition_cipher_unit
// Self-checking bench for the block transposition cipher unit. Message words
// are queued per phase and pushed through a ready/valid driver. Each accepted
// word runs through a local cipher model, and the model's output words are
// checked against the cipher channel in order. Each phase ends on an idle
// block, and the key and mode registers are reloaded between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_block_transposition_cipher_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned L           = btc_pkg::BLOCK_LEN;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_WAIT  = 16;    // pause after all cipher words are back
    localparam int unsigned HOLD_CYCLES = 120;   // long receiver stall
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_WORDS = 33;

    // indexes past the last key register; the block must ignore writes to them
    localparam logic [btc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [btc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } msg_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       blk_end;
        logic       msg_end;
    } cipher_word_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    btc_msg_if    msg_ch ();
    btc_cipher_if cipher_ch ();
    btc_cfg_if    cfg_ch ();

    block_transposition_cipher_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .cipher (cipher_ch),
        .cfg    (cfg_ch)
    );

    always #1 clk = ~clk;

    // ---- stimulus and expectation stores ----------------------------------
    msg_word_t    outgoing_msg_words [$];
    cipher_word_t pending_cipher_words [$];

    // ---- local copy of the cipher state -----------------------------------
    logic [7:0]   block_buf [L];
    int unsigned  block_fill = 0;
    logic         shadow_decrypt = 1'b0;
    logic [2:0]   shadow_key [btc_pkg::KEY_REGS];
    logic [2:0]   next_key [btc_pkg::KEY_REGS];

    // ---- knobs and counters -----------------------------------------------
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_idle_pct = 0;
    logic         hold_start  = 1'b0;
    int unsigned  hold_left   = 0;
    int unsigned  mismatches  = 0;
    int unsigned  words_in    = 0;
    int unsigned  words_out   = 0;
    int unsigned  messages_done = 0;
    int unsigned  cycle_count = 0;

    initial
    begin
        for (int i = 0; i < btc_pkg::KEY_REGS; i++)
        begin
            shadow_key[i] = 3'(i);
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    // append one message word to the stimulus store
    function automatic void queue_word(input logic [7:0] d, input logic fin);
        msg_word_t w;
        w.data = d;
        w.fin  = fin;
        outgoing_msg_words = {outgoing_msg_words, w};
    endfunction

    // Takes one accepted message word. A full block, or any final word,
    // turns the held block into L permuted cipher words.
    function automatic void cipher_block_step(input logic [7:0] d, input logic fin);
        logic [2:0]   src [L];
        logic [7:0]   b;
        logic         last;
        cipher_word_t cw;
        if (block_fill < L)
        begin
            block_buf[block_fill] = d;
        end
        block_fill++;
        if (block_fill < L && !fin)
        begin
            return;
        end
        // short final block gets 'z' padding
        for (int j = block_fill; j < L; j++)
        begin
            block_buf[j] = btc_pkg::PAD_BYTE;
        end
        if (shadow_decrypt)
        begin
            // inverse key: last writer wins on duplicates, missing entries -> 0,
            // out-of-range entries take no part
            for (int j = 0; j < L; j++)
            begin
                src[j] = 3'd0;
            end
            for (int i = 0; i < L; i++)
            begin
                if (key_at(i) < L)
                begin
                    src[key_at(i)] = 3'(i);
                end
            end
        end
        else
        begin
            for (int j = 0; j < L; j++)
            begin
                src[j] = key_at(j);
            end
        end
        for (int j = 0; j < L; j++)
        begin
            b    = (src[j] < L) ? block_buf[src[j]] : btc_pkg::PAD_BYTE;
            last = (j == L - 1);
            cw.ch      = b;
            cw.blk_end = last;
            cw.msg_end = last && fin;
            pending_cipher_words = {pending_cipher_words, cw};
        end
        block_fill = 0;
    endfunction

    // key positions without a register stay at identity
    function automatic logic [2:0] key_at(input int i);
        return (i < btc_pkg::KEY_REGS) ? shadow_key[i] : 3'(i);
    endfunction

    // ---- message driver ---------------------------------------------------
    // Holds a word until it is taken; idles only between words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_ch.valid <= 1'b0;
        end
        else if (!msg_ch.valid || msg_ch.ready)
        begin
            if (msg_ch.valid)
            begin
                cipher_block_step(msg_ch.data_byte, msg_ch.final_byte);
                words_in++;
            end
            if (outgoing_msg_words.size() != 0
                && $urandom_range(99) >= tx_idle_pct)
            begin
                msg_word_t w;
                w = outgoing_msg_words.pop_front();
                msg_ch.data_byte  <= w.data;
                msg_ch.final_byte <= w.fin;
                msg_ch.valid      <= 1'b1;
            end
            else
            begin
                msg_ch.valid <= 1'b0;
            end
        end
    end

    // ---- long receiver hold-off, counted here -----------------------------
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // ---- cipher monitor and checker ---------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_ch.ready <= 1'b0;
        end
        else
        begin
            if (cipher_ch.valid && cipher_ch.ready)
            begin
                cipher_word_t want;
                words_out++;
                if (pending_cipher_words.size() == 0)
                begin
                    report_mismatch($sformatf("cipher word %02h with nothing pending",
                                              cipher_ch.out_byte));
                end
                else
                begin
                    want = pending_cipher_words.pop_front();
                    if (cipher_ch.out_byte !== want.ch)
                        report_mismatch($sformatf("out_byte %02h, want %02h",
                                                  cipher_ch.out_byte, want.ch));
                    if (cipher_ch.block_end !== want.blk_end)
                        report_mismatch($sformatf("block_end %b, want %b",
                                                  cipher_ch.block_end, want.blk_end));
                    if (cipher_ch.message_end !== want.msg_end)
                        report_mismatch($sformatf("message_end %b, want %b",
                                                  cipher_ch.message_end, want.msg_end));
                    if (want.msg_end)
                        messages_done++;
                end
            end
            cipher_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ---- watchdog ---------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---- register writes (only while idle) --------------------------------
    task automatic write_reg(input logic [btc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btc_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        cfg_ch.valid <= 1'b1;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        if (idx == btc_pkg::REG_DECRYPT_MODE)
            shadow_decrypt = val[0];
        else if (idx >= btc_pkg::REG_KEY_POS0
                 && idx < btc_pkg::REG_KEY_POS0 + btc_pkg::KEY_REGS)
            shadow_key[idx - btc_pkg::REG_KEY_POS0] = val;
    endtask

    // mode, all key positions from next_key, then the two spare indexes
    task automatic apply_setting(input logic dec);
        write_reg(btc_pkg::REG_DECRYPT_MODE, {2'b00, dec});
        for (int i = 0; i < btc_pkg::KEY_REGS; i++)
        begin
            write_reg(btc_pkg::REG_KEY_POS0 + 3'(i), next_key[i]);
        end
        write_reg(REG_SPARE_LO, 3'($urandom_range(7)));
        write_reg(REG_SPARE_HI, 3'($urandom_range(7)));
    endtask

    // Everything sent, every cipher word back, then a short pause.
    task automatic wait_idle();
        while (outgoing_msg_words.size() != 0 || msg_ch.valid
               || pending_cipher_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic queue_random_message(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
        begin
            queue_word(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    // ---- main sequence ----------------------------------------------------
    initial
    begin
        int unsigned kind;
        int unsigned len;
        int unsigned queued;
        int unsigned j;
        logic [2:0]  tmp;
        logic        dec;

        msg_ch.valid      = 1'b0;
        msg_ch.data_byte  = 8'h00;
        msg_ch.final_byte = 1'b0;
        cipher_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = btc_pkg::REG_DECRYPT_MODE;
        cfg_ch.data       = 3'd0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset key (identity, encrypt); sender idles little,
        // receiver a lot.
        tx_idle_pct = 8;
        rx_idle_pct = 63;
        // one-word message: final on an empty block, four pad words
        queue_word(8'h00, 1'b1);
        // final on the fifth word: full block, no padding
        queue_word(8'hFF, 1'b0);
        queue_word(8'h01, 1'b0);
        queue_word(8'h80, 1'b0);
        queue_word(btc_pkg::PAD_BYTE, 1'b0);
        queue_word(8'hFE, 1'b1);
        // full block then a two-word padded tail
        queue_word(8'h55, 1'b0);
        queue_word(8'hAA, 1'b0);
        queue_word(8'h0F, 1'b0);
        queue_word(8'hF0, 1'b0);
        queue_word(8'h7F, 1'b0);
        queue_word(8'h81, 1'b0);
        queue_word(8'hFF, 1'b1);
        wait_idle();

        // Decrypt with a broken key: duplicates, out-of-range entries, a hole.
        next_key[0] = 3'd1;
        next_key[1] = 3'd1;
        next_key[2] = 3'd7;
        next_key[3] = 3'd5;
        next_key[4] = 3'd0;
        apply_setting(1'b1);
        for (int i = 0; i < 5; i++)
            queue_word(8'(8'h11 * (i + 1)), 1'b0);
        queue_word(8'h66, 1'b1);
        wait_idle();

        // Same key in encrypt mode: out-of-range positions give 'z'.
        apply_setting(1'b0);
        queue_word(8'hC3, 1'b0);
        queue_word(8'h3C, 1'b0);
        queue_word(8'h99, 1'b1);
        wait_idle();

        // Random phases. Phases 1-4: sender idles little, receiver a lot;
        // 5-8: the reverse; 9-12: no idling, with one long receiver hold.
        for (int unsigned p = 1; p <= PHASES; p++)
        begin
            kind = p % 4;
            if (p <= 4)
            begin
                tx_idle_pct = 8;
                rx_idle_pct = 63;
            end
            else if (p <= 8)
            begin
                tx_idle_pct = 63;
                rx_idle_pct = 8;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (kind == 2)
            begin
                // arbitrary 3-bit entries, out of range and repeats included
                for (int i = 0; i < btc_pkg::KEY_REGS; i++)
                    next_key[i] = 3'($urandom_range(7));
                dec = 1'($urandom_range(1));
            end
            else if (kind == 3)
            begin
                // extremes: all zero or all seven
                for (int i = 0; i < btc_pkg::KEY_REGS; i++)
                    next_key[i] = (p == 3) ? 3'd0 : 3'd7;
                dec = 1'((p / 4) % 2);
            end
            else
            begin
                // proper permutation, shuffled
                for (int i = 0; i < btc_pkg::KEY_REGS; i++)
                    next_key[i] = 3'(i);
                for (int i = btc_pkg::KEY_REGS - 1; i > 0; i--)
                begin
                    j = $urandom_range(i);
                    tmp = next_key[i];
                    next_key[i] = next_key[j];
                    next_key[j] = tmp;
                end
                dec = 1'($urandom_range(1));
            end
            apply_setting(dec);

            // messages of mixed length, on average one in four drawn as a whole number of blocks
            queued = 0;
            while (queued < PHASE_WORDS)
            begin
                if ($urandom_range(3) == 0)
                    len = L * $urandom_range(1, 3);
                else
                    len = $urandom_range(1, 12);
                queue_random_message(len);
                queued += len;
            end

            if (p == 10)
            begin
                // sender keeps offering while the receiver is held off,
                // so the block queue fills and input stalls
                @(negedge clk) hold_start = 1'b1;
                @(negedge clk) hold_start = 1'b0;
            end
            wait_idle();
        end

        $display("covered %0d message words, %0d cipher words, %0d messages,",
                 words_in, words_out, messages_done);
        $display("  %0d key settings: encrypt/decrypt, identity, shuffled, broken, extreme",
                 PHASES + 2);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> block_transposition_cipher_unit.f
hdl/btc_pkg.sv
hdl/btc_if.sv
hdl/btc_front.sv
hdl/btc_queue.sv
hdl/btc_back.sv
hdl/block_transposition_cipher_unit.sv
dv/tb_block_transposition_cipher_unit.sv
